// ----- hdl/tp4ag_pkg.sv -----
// Shared types and constants for the 4-axis tensor permute address generator.
// Holds field widths, register map codes and reset values; depends on nothing.
package tp4ag_pkg;

   localparam int NUM_AXES   = 4;
   localparam int ADDR_W     = 20;  // destination address width
   localparam int VALUE_W    = 32;  // element word width
   localparam int EXT_W      = 11;  // extent register width
   localparam int ORDER_W    = 8;   // four 2-bit axis selects
   localparam int AXIS_SEL_W = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [EXT_W-1:0]   SIZE_RESET  = EXT_W'(1);
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(228);  // identity order

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SIZE_AXIS0 = 3'd0,
      REG_SIZE_AXIS1 = 3'd1,
      REG_SIZE_AXIS2 = 3'd2,
      REG_SIZE_AXIS3 = 3'd3,
      REG_AXIS_ORDER = 3'd4
   } csr_reg_type;

   typedef logic [EXT_W-1:0]      extent_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [AXIS_SEL_W-1:0] axis_sel_type;

   // Multiply-accumulate step of the row-major address, kept modulo 2^ADDR_W.
   function automatic addr_type horner_step(input addr_type acc, input extent_type dim,
                                            input addr_type idx);
      logic [ADDR_W+EXT_W-1:0] prod;
      prod = (ADDR_W+EXT_W)'(acc) * (ADDR_W+EXT_W)'(dim);
      return prod[ADDR_W-1:0] + idx;
   endfunction

   // Field k of the axis order word.
   function automatic axis_sel_type order_field(input logic [ORDER_W-1:0] order,
                                                input logic [AXIS_SEL_W-1:0] k);
      return order[2*k +: AXIS_SEL_W];
   endfunction

endpackage

// ----- hdl/tensor_permute_4d_address_gen_core.sv -----
// A word accepted passes through three registers (accept stage, second address stage,
//   result register) before it shows on the rsp_ side.
// Throughput: one word per cycle while rsp_stall is low; the address is a three-step
//   multiply-add chain, one multiplier per stage, and the counters step once per accepted word.
// Reset (synchronous, active high): extents return to 1, axis order to identity, source
//   counters to zero, pipeline empties. Size writes reach the shape check through p01 and p012.
module tensor_permute_4d_address_gen_core #(
   parameter int MAX_EXTENT   = 1024,
   parameter int MAX_ELEMENTS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   // element input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tp4ag_pkg::VALUE_W-1:0]       req_elem_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tp4ag_pkg::ADDR_W-1:0]        rsp_dest_address,
   output logic [tp4ag_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                                rsp_last_element,
   output logic                                rsp_shape_error,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tp4ag_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tp4ag_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tp4ag_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import tp4ag_pkg::*;

   // Counter width covers 0..MAX_EXTENT-1; compares run one bit wider than either side.
   localparam int IDX_W = (MAX_EXTENT > 2) ? $clog2(MAX_EXTENT) : 1;
   localparam int CMP_W = ((IDX_W > EXT_W) ? IDX_W : EXT_W) + 1;
   // Element-count check saturates at MAX_ELEMENTS+1 so it never needs the full 44 bits.
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);
   localparam int OPW   = (CNT_W > EXT_W) ? CNT_W : EXT_W;
   localparam int PW    = OPW + EXT_W;
   localparam logic [31:0]   MAX_EXT_U = 32'(MAX_EXTENT);
   localparam logic [PW-1:0] MAX_ELEM  = PW'(MAX_ELEMENTS);
   localparam logic [OPW-1:0] CNT_SAT  = OPW'(MAX_ELEMENTS + 1);

   typedef logic [IDX_W-1:0] idx_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   extent_type           size_ff [NUM_AXES];
   logic [ORDER_W-1:0]   order_ff;
   logic                 csr_write;
   csr_reg_type          csr_sel;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[REG_IDX_W+1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) size_ff[k] <= SIZE_RESET;
         order_ff <= ORDER_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_SIZE_AXIS0: size_ff[0] <= csr_pwdata[EXT_W-1:0];
            REG_SIZE_AXIS1: size_ff[1] <= csr_pwdata[EXT_W-1:0];
            REG_SIZE_AXIS2: size_ff[2] <= csr_pwdata[EXT_W-1:0];
            REG_SIZE_AXIS3: size_ff[3] <= csr_pwdata[EXT_W-1:0];
            REG_AXIS_ORDER: order_ff   <= csr_pwdata[ORDER_W-1:0];
            default: ;  // drop writes past the register map
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SIZE_AXIS0: csr_prdata = CSR_DATA_W'(size_ff[0]);
         REG_SIZE_AXIS1: csr_prdata = CSR_DATA_W'(size_ff[1]);
         REG_SIZE_AXIS2: csr_prdata = CSR_DATA_W'(size_ff[2]);
         REG_SIZE_AXIS3: csr_prdata = CSR_DATA_W'(size_ff[3]);
         REG_AXIS_ORDER: csr_prdata = CSR_DATA_W'(order_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Extents: clamp each to 1..MAX_EXTENT for counting and for the
   // destination dimensions.
   // ------------------------------------------------------------------------
   function automatic extent_type clamp_extent(input extent_type e);
      if (e == '0) return EXT_W'(1);
      else if (32'(e) > MAX_EXT_U) return EXT_W'(MAX_EXTENT);
      else return e;
   endfunction

   extent_type ext_c [NUM_AXES];  // clamped source extents
   extent_type dim   [NUM_AXES];  // clamped destination extents
   axis_sel_type ord [NUM_AXES];

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         ext_c[k] = clamp_extent(size_ff[k]);
         ord[k]   = order_field(order_ff, AXIS_SEL_W'(k));
      end
      for (int k = 0; k < NUM_AXES; k++) dim[k] = ext_c[ord[k]];
   end

   // ------------------------------------------------------------------------
   // Shape check. The element count runs through two saturating product
   // registers; the last multiply and compare feed the result register.
   // ------------------------------------------------------------------------
   function automatic logic [OPW-1:0] sat_count(input logic [PW-1:0] p);
      if (p > MAX_ELEM) return CNT_SAT;
      else return p[OPW-1:0];
   endfunction

   logic [OPW-1:0] p01_ff,  p01_in;
   logic [OPW-1:0] p012_ff, p012_in;
   logic [PW-1:0]  p_all;
   logic           count_over;
   logic           size_bad;
   logic           order_bad;
   logic [NUM_AXES-1:0] seen;
   logic           shape_err;

   always_comb begin
      p01_in     = sat_count(PW'(size_ff[0]) * PW'(size_ff[1]));
      p012_in    = sat_count(PW'(p01_ff) * PW'(size_ff[2]));
      p_all      = PW'(p012_ff) * PW'(size_ff[3]);
      count_over = p_all > MAX_ELEM;
      size_bad   = 1'b0;
      seen       = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         size_bad      = size_bad || (size_ff[k] == '0) || (32'(size_ff[k]) > MAX_EXT_U);
         seen[ord[k]]  = 1'b1;
      end
      order_bad = ~&seen;
      shape_err = size_bad || order_bad || count_over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p01_ff  <= OPW'(1);
         p012_ff <= OPW'(1);
      end else begin
         p01_ff  <= p01_in;
         p012_ff <= p012_in;
      end
   end

   // ------------------------------------------------------------------------
   // Handshake: each stage loads when it is empty or its contents move on.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic rsp_load, s2_free, s1_free, req_accept;

   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || rsp_load;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_valid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (rsp_load) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Source position counters: axis 3 fastest, carry outward. A counter at or
   // past its extent (after an extent change) wraps on its next step.
   // ------------------------------------------------------------------------
   idx_type idx_ff [NUM_AXES];
   idx_type idx_in [NUM_AXES];
   logic [NUM_AXES-1:0] wrap;
   logic last_now;

   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int k = NUM_AXES - 1; k >= 0; k--) begin
         wrap[k]   = (CMP_W'(idx_ff[k]) + CMP_W'(1)) >= CMP_W'(ext_c[k]);
         idx_in[k] = idx_ff[k];
         if (carry) idx_in[k] = wrap[k] ? '0 : idx_ff[k] + IDX_W'(1);
         carry = carry && wrap[k];
      end
      last_now = &wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) idx_ff[k] <= '0;
      end else if (req_accept) begin
         for (int k = 0; k < NUM_AXES; k++) idx_ff[k] <= idx_in[k];
      end
   end

   // ------------------------------------------------------------------------
   // Address: ((j0*d1 + j1)*d2 + j2)*d3 + j3, where jk is the source index
   // named by order field k. One multiply-add per stage.
   // ------------------------------------------------------------------------
   addr_type perm_idx [NUM_AXES];

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) perm_idx[k] = ADDR_W'(idx_ff[ord[k]]);
   end

   // stage 1
   addr_type               s1_acc_ff, s1_acc_in;
   addr_type               s1_j2_ff, s1_j3_ff;
   logic [VALUE_W-1:0]     s1_value_ff;
   logic                   s1_last_ff;

   assign s1_acc_in = horner_step(perm_idx[0], dim[1], perm_idx[1]);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_acc_ff   <= s1_acc_in;
         s1_j2_ff    <= perm_idx[2];
         s1_j3_ff    <= perm_idx[3];
         s1_value_ff <= req_elem_value;
         s1_last_ff  <= last_now;
      end
   end

   // stage 2
   addr_type               s2_acc_ff, s2_acc_in;
   addr_type               s2_j3_ff;
   logic [VALUE_W-1:0]     s2_value_ff;
   logic                   s2_last_ff;

   assign s2_acc_in = horner_step(s1_acc_ff, dim[2], s1_j2_ff);

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_acc_ff   <= s2_acc_in;
         s2_j3_ff    <= s1_j3_ff;
         s2_value_ff <= s1_value_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // result register; a bad shape forces the address to zero
   addr_type               rsp_addr_ff, rsp_addr_in;
   logic [VALUE_W-1:0]     rsp_value_ff;
   logic                   rsp_last_ff;
   logic                   rsp_err_ff;

   assign rsp_addr_in = shape_err ? '0 : horner_step(s2_acc_ff, dim[3], s2_j3_ff);

   always_ff @(posedge clock) begin
      if (rsp_load && s2_valid_ff) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_value_ff <= s2_value_ff;
         rsp_last_ff  <= s2_last_ff;
         rsp_err_ff   <= shape_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = rsp_addr_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_last_element = rsp_last_ff;
   assign rsp_shape_error  = rsp_err_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   // The pipeline empties on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // Input stalls only when every stage is full and the result side holds.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // The word that closes a tensor restarts every counter at zero.
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_now) |=>
         (idx_ff[0] == '0 && idx_ff[1] == '0 && idx_ff[2] == '0 && idx_ff[3] == '0))
      else $error("counters did not restart after last element");

   // A flagged shape never carries an address.
   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_addr_ff == '0))
      else $error("nonzero address with shape error");

endmodule
